### hdl/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants for the scrolling LED matrix scanner
// Field widths, register indexes, item kinds and the payload structs that
// travel on the input and result channels.
// ----------------------------------------------------------------------------
package sls_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int unsigned STORE_DEPTH_DEFAULT  = 512;
	localparam int unsigned CHAR_COLUMNS_DEFAULT = 16;

	// Fixed field widths.
	localparam int unsigned ADDRESS_W = 9;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COLUMN_W  = 4;
	localparam int unsigned OFFSET_W  = 9;
	localparam int unsigned SUM_W     = OFFSET_W + 1;
	localparam int unsigned DIVIDER_W = 8;
	localparam int unsigned CHARS_W   = 6;
	localparam int unsigned PERIOD_W  = 8;

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_CHAR_COUNT    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_PERIOD = 1'd1;

	localparam logic [CHARS_W-1:0]  CHAR_COUNT_RESET    = 6'd0;
	localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RESET = 8'd250;
	localparam logic [COLUMN_W-1:0] COLUMN_RESET        = 4'd15;

	// Item kinds.
	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic [ADDRESS_W-1:0] address;
		logic [BYTE_W-1:0]    upper_byte;
		logic [BYTE_W-1:0]    lower_byte;
	} in_item_t;

	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic                right_half;
		logic [BYTE_W-1:0]   upper_rows;
		logic [BYTE_W-1:0]   lower_rows;
	} out_item_t;

	// Scan position for the tick now being accepted.
	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic                right_half;
		logic [SUM_W-1:0]    store_addr;
	} tick_info_t;

endpackage

### hdl/sls_if.sv
// ----------------------------------------------------------------------------
// sls_in_if / sls_out_if: valid/ready channels of the scanner
// One interface per channel; each carries valid, ready and one payload word.
// ----------------------------------------------------------------------------
interface sls_in_if;
	logic              valid;
	logic              ready;
	sls_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sls_out_if;
	logic               valid;
	logic               ready;
	sls_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/scrolling_led_matrix_scan.sv
// ----------------------------------------------------------------------------
// scrolling_led_matrix_scan: 16-column LED matrix scanner with scrolling
// A tick's result passes the store read register, then the output register.
// Throughput: one item per cycle while the result channel is not stalled.
// After reset the column stores are cleared, one entry per cycle over all
// STORE_DEPTH entries (512 by default); no item is accepted until this
// finishes, while configuration writes are taken at once.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_scan #(
	parameter int unsigned STORE_DEPTH  = sls_pkg::STORE_DEPTH_DEFAULT,
	parameter int unsigned CHAR_COLUMNS = sls_pkg::CHAR_COLUMNS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sls_in_if.sink                          items,
	sls_out_if.source                       results,
	input  logic                            cfg_we,
	input  logic [sls_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sls_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned AW     = $clog2(STORE_DEPTH);
	localparam int unsigned WORD_W = 2 * sls_pkg::BYTE_W;

	sls_pkg::tick_info_t tick_info;

	logic              clearing_q;
	logic [AW-1:0]     clr_addr_q;
	logic              accept;
	logic              tick_acc;
	logic              write_acc;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic                         valid_s1;
	logic [sls_pkg::COLUMN_W-1:0] column_s1;
	logic                         right_half_s1;
	logic                         in_range_s1;
	logic                         adv_s1;

	logic               valid_s2;
	sls_pkg::out_item_t result_s2;

	// Handshake: s1 may refill when empty or when it moves on to s2.
	assign adv_s1       = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready  = !clearing_q && (!valid_s1 || adv_s1);
	assign accept       = items.valid && items.ready;
	assign tick_acc     = accept && (items.data.kind == sls_pkg::KIND_TICK);
	assign write_acc    = accept && (items.data.kind == sls_pkg::KIND_WRITE)
		&& (32'(items.data.address) < STORE_DEPTH);

	sls_ctrl #(
		.STORE_DEPTH  (STORE_DEPTH),
		.CHAR_COLUMNS (CHAR_COLUMNS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_en   (tick_acc),
		.tick_info (tick_info)
	);

	// Clearing pass over the column stores after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Write port is shared by the clearing pass and write items.
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = write_acc;
			ram_waddr = AW'(items.data.address);
			ram_wdata = {items.data.upper_byte, items.data.lower_byte};
		end
	end

	// Upper byte in the high half of each word, lower byte in the low half.
	sls_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (tick_acc),
		.raddr (AW'(tick_info.store_addr)),
		.rdata (ram_rdata)
	);

	// Stage 1: scan position alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= tick_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			column_s1     <= tick_info.column;
			right_half_s1 <= tick_info.right_half;
			in_range_s1   <= 32'(tick_info.store_addr) < STORE_DEPTH;
		end
	end

	// Stage 2: output register; rows past the store end read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2.column     <= column_s1;
			result_s2.right_half <= right_half_s1;
			result_s2.upper_rows <= in_range_s1 ? ram_rdata[WORD_W-1:sls_pkg::BYTE_W] : '0;
			result_s2.lower_rows <= in_range_s1 ? ram_rdata[sls_pkg::BYTE_W-1:0] : '0;
		end
	end

	assign results.valid = valid_s2;
	assign results.data  = result_s2;

endmodule

### hdl/sls_ram.sv
// ----------------------------------------------------------------------------
// sls_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sls_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; holds its word while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/sls_ctrl.sv
// ----------------------------------------------------------------------------
// sls_ctrl: configuration registers and scan counters
// Holds char_count and scroll_period, the tick divider, the scroll offset
// and the scan column, and gives the scan position of the accepted tick.
// ----------------------------------------------------------------------------
module sls_ctrl #(
	parameter int unsigned STORE_DEPTH  = sls_pkg::STORE_DEPTH_DEFAULT,
	parameter int unsigned CHAR_COLUMNS = sls_pkg::CHAR_COLUMNS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sls_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sls_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             tick_en,
	output sls_pkg::tick_info_t              tick_info
);

	localparam int unsigned LIMIT_W = sls_pkg::CHARS_W + $clog2(CHAR_COLUMNS + 1);

	logic [sls_pkg::CHARS_W-1:0]   char_count_q;
	logic [sls_pkg::PERIOD_W-1:0]  scroll_period_q;
	logic [sls_pkg::DIVIDER_W-1:0] divider_q;
	logic [sls_pkg::OFFSET_W-1:0]  offset_q;
	logic [sls_pkg::COLUMN_W-1:0]  column_q;

	logic [sls_pkg::DIVIDER_W-1:0] divider_inc;
	logic [sls_pkg::DIVIDER_W-1:0] divider_d;
	logic [sls_pkg::OFFSET_W-1:0]  offset_d;
	logic [sls_pkg::COLUMN_W-1:0]  column_d;
	logic [sls_pkg::SUM_W-1:0]     offset_inc;
	logic [LIMIT_W-1:0]            limit;
	logic                          wrap;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q    <= sls_pkg::CHAR_COUNT_RESET;
			scroll_period_q <= sls_pkg::SCROLL_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sls_pkg::REG_CHAR_COUNT:    char_count_q <= cfg_data[sls_pkg::CHARS_W-1:0];
				sls_pkg::REG_SCROLL_PERIOD: scroll_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next divider, offset and column for a tick.
	always_comb begin
		divider_inc = divider_q + 1'b1;
		limit       = LIMIT_W'(char_count_q) * LIMIT_W'(CHAR_COLUMNS);
		offset_inc  = {1'b0, offset_q} + 1'b1;
		// The offset returns to zero at the message end or the store end.
		wrap        = (32'(offset_inc) >= 32'(limit)) || (32'(offset_inc) >= STORE_DEPTH);
		divider_d   = divider_inc;
		offset_d    = offset_q;
		if (divider_inc > scroll_period_q) begin
			divider_d = '0;
			offset_d  = wrap ? '0 : offset_inc[sls_pkg::OFFSET_W-1:0];
		end
		column_d = column_q + 1'b1;

		tick_info.column     = column_d;
		tick_info.right_half = column_d[sls_pkg::COLUMN_W-1];
		tick_info.store_addr = sls_pkg::SUM_W'(column_d) + {1'b0, offset_d};
	end

	// Scan state advances on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= '0;
			offset_q  <= '0;
			column_q  <= sls_pkg::COLUMN_RESET;
		end else if (tick_en) begin
			divider_q <= divider_d;
			offset_q  <= offset_d;
			column_q  <= column_d;
		end
	end

endmodule
